// ===== src/aifs_pkg.sv =====
// ----------------------------------------------------------------------------
// aifs_pkg: shared types and constants of the integer field scanner
// Character codes, register indexes, radix and result-size codes, the phase
// encoding and the digit decoder used by the scanner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aifs_pkg;

   // Width of the result value on the response channel.
   localparam int OUT_BITS = 64;

   // Register indexes on the CSR write port.
   localparam logic [1:0] CSR_RADIX_MODE  = 2'd0;
   localparam logic [1:0] CSR_WIDTH_LIMIT = 2'd1;
   localparam logic [1:0] CSR_IS_SIGNED   = 2'd2;
   localparam logic [1:0] CSR_RESULT_SIZE = 2'd3;

   // Radix mode register codes.
   localparam logic [1:0] MODE_AUTO = 2'd0;
   localparam logic [1:0] MODE_OCT  = 2'd1;
   localparam logic [1:0] MODE_DEC  = 2'd2;
   localparam logic [1:0] MODE_HEX  = 2'd3;

   // Result size register codes.
   localparam logic [1:0] SIZE_8  = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_32 = 2'd2;
   localparam logic [1:0] SIZE_64 = 2'd3;

   // Reset values of the configuration registers.
   localparam logic [1:0] RADIX_MODE_RESET  = MODE_DEC;
   localparam logic [7:0] WIDTH_LIMIT_RESET = 8'd0;
   localparam logic       IS_SIGNED_RESET   = 1'b1;
   localparam logic [1:0] RESULT_SIZE_RESET = SIZE_32;

   // Character codes.
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_A_UPPER = 8'h41;
   localparam logic [7:0] CH_F_UPPER = 8'h46;
   localparam logic [7:0] CH_X_UPPER = 8'h58;
   localparam logic [7:0] CH_A_LOWER = 8'h61;
   localparam logic [7:0] CH_F_LOWER = 8'h66;
   localparam logic [7:0] CH_X_LOWER = 8'h78;

   // Scan phase of the current field.
   typedef enum logic [3:0] {
      PHASE_SKIP   = 4'b0001,
      PHASE_SIGN   = 4'b0010,
      PHASE_ZERO   = 4'b0100,
      PHASE_DIGITS = 4'b1000
   } phase_type;

   // Radix in force for the current field.
   typedef enum logic [1:0] {
      RADIX_OCT = 2'd0,
      RADIX_DEC = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   // Decoded hex digit.
   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // Field flags handed from the scan stage to the result stage.
   typedef struct packed {
      logic       negative;
      logic       saturated;
      logic       digit_seen;
      logic       returned;
      logic       is_signed;
      logic [1:0] result_size;
   } snap_type;

   // Digit value of a character, valid only for hex digits.
   function automatic digit_type digit_of(input logic [7:0] c);
      digit_type r;
      r.valid = 1'b1;
      r.value = 4'd0;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
         r.value = 4'(c - CH_ZERO);
      end else if (c inside {[CH_A_LOWER:CH_F_LOWER]}) begin
         r.value = 4'(c - CH_A_LOWER + 8'd10);
      end else if (c inside {[CH_A_UPPER:CH_F_UPPER]}) begin
         r.value = 4'(c - CH_A_UPPER + 8'd10);
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

   // Numeric value of a radix code.
   function automatic logic [4:0] radix_value(input radix_type r);
      logic [4:0] v;
      case (r)
         RADIX_OCT: v = 5'd8;
         RADIX_HEX: v = 5'd16;
         default:   v = 5'd10;
      endcase
      return v;
   endfunction

   // Radix selected by the mode register when a field starts.
   function automatic radix_type mode_radix(input logic [1:0] mode);
      radix_type r;
      case (mode)
         MODE_OCT: r = RADIX_OCT;
         MODE_HEX: r = RADIX_HEX;
         default:  r = RADIX_DEC;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== src/aifs_req_if.sv =====
// ----------------------------------------------------------------------------
// aifs_req_if: character request channel
// Valid/ready channel carrying one character byte and the end-of-input flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface aifs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       at_end;

   modport source (output valid, output ch, output at_end, input ready);
   modport sink   (input valid, input ch, input at_end, output ready);
endinterface

`default_nettype wire

// ===== src/aifs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// aifs_rsp_if: scan result channel
// Valid/ready channel carrying the converted value and the field status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface aifs_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic        no_digits;
   logic        char_returned;

   modport source (output valid, output value, output no_digits, output char_returned,
                   input ready);
   modport sink   (input valid, input value, input no_digits, input char_returned,
                   output ready);
endinterface

`default_nettype wire

// ===== src/aifs_finish.sv =====
// ----------------------------------------------------------------------------
// aifs_finish: saturation and result cut
// Turns a finished field's magnitude and flags into the result value:
// saturates as a signed or unsigned integer, applies the sign, extends to
// the output width and cuts to the selected result size.
// ----------------------------------------------------------------------------
`default_nettype none

module aifs_finish
   import aifs_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  wire logic [VALUE_BITS-1:0] acc,
   input  wire snap_type              snap,
   output logic      [OUT_BITS-1:0]   value,
   output logic                       no_digits,
   output logic                       char_returned
);

   localparam logic [VALUE_BITS-1:0] VSIGN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] VMAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] VMASK = {VALUE_BITS{1'b1}};

   logic [VALUE_BITS-1:0] neg_mag;
   logic [VALUE_BITS-1:0] sat_val;
   logic                  over_min;
   logic [OUT_BITS-1:0]   ext_val;

   assign neg_mag  = VALUE_BITS'(0) - acc;
   // Magnitude above the most negative value's magnitude.
   assign over_min = acc[VALUE_BITS-1] && (|acc[VALUE_BITS-2:0]);

   // Saturate and apply the sign.
   always_comb begin
      sat_val = '0;
      if (snap.digit_seen) begin
         if (snap.is_signed) begin
            if (snap.negative) begin
               sat_val = (snap.saturated || over_min) ? VSIGN : neg_mag;
            end else begin
               sat_val = (snap.saturated || acc[VALUE_BITS-1]) ? VMAX : acc;
            end
         end else begin
            if (snap.saturated) begin
               sat_val = VMASK;
            end else begin
               sat_val = snap.negative ? neg_mag : acc;
            end
         end
      end
   end

   // Signed results extend with their sign bit, unsigned ones with zeros.
   assign ext_val = snap.is_signed ? OUT_BITS'($signed(sat_val)) : OUT_BITS'(sat_val);

   // Cut to the result size.
   always_comb begin
      case (snap.result_size)
         SIZE_8:  value = {{(OUT_BITS-8){1'b0}}, ext_val[7:0]};
         SIZE_16: value = {{(OUT_BITS-16){1'b0}}, ext_val[15:0]};
         SIZE_32: value = {{(OUT_BITS-32){1'b0}}, ext_val[31:0]};
         default: value = ext_val;
      endcase
   end

   assign no_digits     = !snap.digit_seen;
   assign char_returned = snap.returned;

endmodule

`default_nettype wire

// ===== src/ascii_integer_field_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_field_scanner_unit: character-serial integer field scanner
// Scans one integer field from a character stream, scanf style, and returns
// the saturated, sign-applied value cut to the configured size.
// ----------------------------------------------------------------------------
// The unit takes one character per clock cycle and can accept a character in
// every cycle while the request side is not stalled. White space ahead of the
// field is skipped, then an optional sign, an optional 0 or 0x prefix and the
// digits are consumed. The field ends on end of input, a zero byte, a character
// that is no digit of the radix (flagged as returned, so the caller presents it
// again) or when the field width is reached; only that character produces a
// response. The cycle that accepts it runs the digit shift-and-add of the scan
// stage into the scan-to-result register; the saturation and cut of the result
// stage then go into the response register. The request side stalls only while
// both the result stage and the response register hold a result and the
// response is not taken. Configuration is to be written through the CSR port
// only while no field is being scanned; the block itself does not enforce this.
`default_nettype none

module ascii_integer_field_scanner_unit
   import aifs_pkg::*;
#(
   parameter int VALUE_BITS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   aifs_req_if.sink         req_if,
   aifs_rsp_if.source       rsp_if,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_write_data
);

   localparam int SUM_BITS = VALUE_BITS + 5;

   // Configuration registers.
   logic [1:0] radix_mode_ff;
   logic [7:0] width_limit_ff;
   logic       is_signed_ff;
   logic [1:0] result_size_ff;

   // Field state.
   phase_type             phase_ff,      phase_in;
   radix_type             radix_ff,      radix_in;
   logic [VALUE_BITS-1:0] acc_ff,        acc_in;
   logic                  negative_ff,   negative_in;
   logic                  saturated_ff,  saturated_in;
   logic [7:0]            count_ff,      count_in;
   logic                  digit_seen_ff, digit_seen_in;

   // Scan-to-result stage and response register.
   logic                  snap_valid_ff;
   logic [VALUE_BITS-1:0] snap_acc_ff;
   snap_type              snap_ff;
   snap_type              snap_in;
   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   rsp_value_ff;
   logic                  rsp_no_digits_ff;
   logic                  rsp_returned_ff;

   logic                  advance;
   logic                  req_fire;
   logic                  is_end;
   logic                  is_space;
   digit_type             dig;
   radix_type             radix_work;
   logic [SUM_BITS-1:0]   acc_wide;
   logic [SUM_BITS-1:0]   product;
   logic [SUM_BITS-1:0]   sum;
   logic                  overflow;
   logic                  consume;
   logic                  do_digit;
   logic                  step_fin;
   logic                  step_ret;
   logic [OUT_BITS-1:0]   fin_value;
   logic                  fin_no_digits;
   logic                  fin_returned;

   // Pipeline handshake: the scan stage moves on when the result stage does.
   assign advance      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = !snap_valid_ff || advance;
   assign req_fire     = req_if.valid && req_if.ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_mode_ff  <= RADIX_MODE_RESET;
         width_limit_ff <= WIDTH_LIMIT_RESET;
         is_signed_ff   <= IS_SIGNED_RESET;
         result_size_ff <= RESULT_SIZE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RADIX_MODE:  radix_mode_ff  <= csr_write_data[1:0];
            CSR_WIDTH_LIMIT: width_limit_ff <= csr_write_data;
            CSR_IS_SIGNED:   is_signed_ff   <= csr_write_data[0];
            CSR_RESULT_SIZE: result_size_ff <= csr_write_data[1:0];
            default: ;
         endcase
      end
   end

   // Character classification.
   assign is_end   = req_if.at_end || (req_if.ch == CH_NUL);
   assign is_space = req_if.ch inside {[CH_TAB:CH_CR], CH_SPACE};
   assign dig      = digit_of(req_if.ch);

   // The radix is taken from the mode register on the first non-space byte.
   assign radix_work = (phase_ff == PHASE_SKIP) ? mode_radix(radix_mode_ff) : radix_ff;

   // Digit accumulate: shift-and-add by the fixed radix, with overflow check.
   assign acc_wide = SUM_BITS'(acc_ff);
   always_comb begin
      case (radix_work)
         RADIX_OCT: product = acc_wide << 3;
         RADIX_HEX: product = acc_wide << 4;
         default:   product = (acc_wide << 3) + (acc_wide << 1);
      endcase
   end
   assign sum      = product + SUM_BITS'(dig.value);
   assign overflow = |sum[SUM_BITS-1:VALUE_BITS];

   // Scan step for one character.
   always_comb begin
      phase_in      = phase_ff;
      radix_in      = radix_ff;
      acc_in        = acc_ff;
      negative_in   = negative_ff;
      saturated_in  = saturated_ff;
      count_in      = count_ff;
      digit_seen_in = digit_seen_ff;
      consume       = 1'b0;
      do_digit      = 1'b0;
      step_fin      = 1'b0;
      step_ret      = 1'b0;

      if (is_end) begin
         step_fin = 1'b1;
      end else if (!(phase_ff == PHASE_SKIP && is_space)) begin
         radix_in = radix_work;
         if (phase_ff == PHASE_SKIP && (req_if.ch == CH_PLUS || req_if.ch == CH_MINUS)) begin
            negative_in = (req_if.ch == CH_MINUS);
            phase_in    = PHASE_SIGN;
            consume     = 1'b1;
         end else if (phase_ff == PHASE_SKIP || phase_ff == PHASE_SIGN) begin
            if (req_if.ch == CH_ZERO &&
                (radix_mode_ff == MODE_AUTO || radix_mode_ff == MODE_HEX)) begin
               // Prefix zero counts as a digit and picks the radix.
               radix_in      = (radix_mode_ff == MODE_AUTO) ? RADIX_OCT : RADIX_HEX;
               digit_seen_in = 1'b1;
               phase_in      = PHASE_ZERO;
               consume       = 1'b1;
            end else begin
               phase_in = PHASE_DIGITS;
               do_digit = 1'b1;
            end
         end else if (phase_ff == PHASE_ZERO) begin
            phase_in = PHASE_DIGITS;
            if (req_if.ch == CH_X_LOWER || req_if.ch == CH_X_UPPER) begin
               radix_in = RADIX_HEX;
               consume  = 1'b1;
            end else begin
               do_digit = 1'b1;
            end
         end else begin
            do_digit = 1'b1;
         end

         if (do_digit) begin
            if (!dig.valid || ({1'b0, dig.value} >= radix_value(radix_work))) begin
               step_fin = 1'b1;
               step_ret = 1'b1;
            end else begin
               digit_seen_in = 1'b1;
               consume       = 1'b1;
               if (!saturated_ff) begin
                  if (overflow) begin
                     saturated_in = 1'b1;
                  end else begin
                     acc_in = sum[VALUE_BITS-1:0];
                  end
               end
            end
         end

         // Count consumed bytes; the field ends when the width is reached.
         if (consume) begin
            count_in = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;
            if (width_limit_ff != 8'd0 && count_in >= width_limit_ff) begin
               step_fin = 1'b1;
            end
         end
      end
   end

   // Flags of the finished field.
   always_comb begin
      snap_in.negative    = negative_in;
      snap_in.saturated   = saturated_in;
      snap_in.digit_seen  = digit_seen_in;
      snap_in.returned    = step_ret;
      snap_in.is_signed   = is_signed_ff;
      snap_in.result_size = result_size_ff;
   end

   // Field state update; a finished field clears it.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_SKIP;
         radix_ff      <= RADIX_DEC;
         acc_ff        <= '0;
         negative_ff   <= 1'b0;
         saturated_ff  <= 1'b0;
         count_ff      <= 8'd0;
         digit_seen_ff <= 1'b0;
      end else if (req_fire) begin
         if (step_fin) begin
            phase_ff      <= PHASE_SKIP;
            radix_ff      <= RADIX_DEC;
            acc_ff        <= '0;
            negative_ff   <= 1'b0;
            saturated_ff  <= 1'b0;
            count_ff      <= 8'd0;
            digit_seen_ff <= 1'b0;
         end else begin
            phase_ff      <= phase_in;
            radix_ff      <= radix_in;
            acc_ff        <= acc_in;
            negative_ff   <= negative_in;
            saturated_ff  <= saturated_in;
            count_ff      <= count_in;
            digit_seen_ff <= digit_seen_in;
         end
      end
   end

   // Scan-to-result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         snap_valid_ff <= req_fire && step_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && step_fin) begin
         snap_acc_ff <= acc_in;
         snap_ff     <= snap_in;
      end
   end

   aifs_finish #(
      .VALUE_BITS (VALUE_BITS)
   ) u_finish (
      .acc           (snap_acc_ff),
      .snap          (snap_ff),
      .value         (fin_value),
      .no_digits     (fin_no_digits),
      .char_returned (fin_returned)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && snap_valid_ff) begin
         rsp_value_ff     <= fin_value;
         rsp_no_digits_ff <= fin_no_digits;
         rsp_returned_ff  <= fin_returned;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.value         = rsp_value_ff;
   assign rsp_if.no_digits     = rsp_no_digits_ff;
   assign rsp_if.char_returned = rsp_returned_ff;

   // A finished field leaves the scanner ready for the next one.
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && step_fin) |=>
         (phase_ff == PHASE_SKIP && !digit_seen_ff && count_ff == 8'd0))
      else $error("field state not cleared after a finished field");

   // Nothing accumulates before the first digit.
   a_acc_needs_digit: assert property (@(posedge clock) disable iff (reset)
      !digit_seen_ff |-> (acc_ff == '0 && !saturated_ff))
      else $error("accumulator changed without a digit");

   // While skipping white space no byte has been counted and no sign taken.
   a_skip_is_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_SKIP) |-> (count_ff == 8'd0 && !negative_ff))
      else $error("stale field state while skipping white space");

   // A matching failure always reports a zero value.
   a_no_digits_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_no_digits_ff) |-> (rsp_value_ff == '0))
      else $error("nonzero value on a matching failure");

endmodule

`default_nettype wire

// ===== tb/ascii_integer_field_scanner_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ascii_integer_field_scanner_unit_tb: self-checking bench for the scanner
// Drives character requests over the valid/ready channel under several radix,
// width, signedness and size settings. A scoreboard class tracks the field
// scan and predicts each response, which is compared field by field.
// ----------------------------------------------------------------------------

module ascii_integer_field_scanner_unit_tb;
   import aifs_pkg::*;

   localparam int VALUE_BITS = 64;
   localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);
   localparam logic [63:0] VALUE_SIGN = 64'd1 << (VALUE_BITS - 1);
   localparam int PHASE_COUNT = 12;
   localparam int REQUESTS_PER_PHASE = 84;
   localparam int PRESSURE_CYCLES = 300;

   // One predicted response.
   typedef struct {
      logic [63:0] value;
      logic        no_digits;
      logic        char_returned;
   } field_result_type;

   // Tracks the field being scanned and holds the responses it predicts.
   class field_value_tracker;
      logic [1:0]       radix_mode;
      logic [7:0]       width_limit;
      logic             is_signed;
      logic [1:0]       result_size;
      phase_type        scan_phase;
      logic [63:0]      accumulator;
      bit               negative;
      bit               saturated;
      bit               digit_seen;
      int unsigned      chars_counted;
      int unsigned      field_radix;
      field_result_type expected_fields[$];
      int               errors;

      function new();
         radix_mode  = RADIX_MODE_RESET;
         width_limit = WIDTH_LIMIT_RESET;
         is_signed   = IS_SIGNED_RESET;
         result_size = RESULT_SIZE_RESET;
         errors      = 0;
         clear_field();
      endfunction

      function void clear_field();
         scan_phase    = PHASE_SKIP;
         accumulator   = '0;
         negative      = 0;
         saturated     = 0;
         digit_seen    = 0;
         chars_counted = 0;
         field_radix   = 10;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] data);
         case (idx)
            CSR_RADIX_MODE:  radix_mode = data[1:0];
            CSR_WIDTH_LIMIT: width_limit = data;
            CSR_IS_SIGNED:   is_signed = data[0];
            default:         result_size = data[1:0];
         endcase
      endfunction

      // Saturate, apply the sign, cut to the result size and queue the response.
      function void close_field(bit returned);
         logic [63:0]      v;
         logic [63:0]      mag;
         logic [63:0]      cut;
         field_result_type r;
         v = '0;
         if (digit_seen) begin
            mag = accumulator & VALUE_MASK;
            if (is_signed) begin
               if (negative) begin
                  v = (saturated || mag > VALUE_SIGN) ? VALUE_SIGN : ((64'd0 - mag) & VALUE_MASK);
               end else begin
                  v = (saturated || mag > VALUE_SIGN - 1) ? (VALUE_SIGN - 1) : mag;
               end
               if ((v & VALUE_SIGN) != 0) v = v | ~VALUE_MASK;
            end else if (saturated) begin
               v = VALUE_MASK;
            end else begin
               v = negative ? ((64'd0 - mag) & VALUE_MASK) : mag;
            end
         end
         case (result_size)
            SIZE_8:  cut = 64'hFF;
            SIZE_16: cut = 64'hFFFF;
            SIZE_32: cut = 64'hFFFF_FFFF;
            default: cut = {64{1'b1}};
         endcase
         r.value = v & cut;
         r.no_digits = !digit_seen;
         r.char_returned = returned;
         expected_fields.push_back(r);
         clear_field();
      endfunction

      // Count a consumed character; the field closes when the width is reached.
      function void count_char();
         if (chars_counted < 255) chars_counted++;
         if (width_limit != 0 && chars_counted >= width_limit) close_field(0);
      endfunction

      // Advance the scan by one accepted request.
      function void take_char(logic [7:0] c, logic at_end);
         int unsigned d;
         if (at_end || c == CH_NUL) begin
            close_field(0);
            return;
         end
         if (scan_phase == PHASE_SKIP) begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
            case (radix_mode)
               MODE_OCT: field_radix = 8;
               MODE_HEX: field_radix = 16;
               default:  field_radix = 10;
            endcase
            if (c == CH_PLUS || c == CH_MINUS) begin
               negative = (c == CH_MINUS);
               scan_phase = PHASE_SIGN;
               count_char();
               return;
            end
         end
         if (scan_phase == PHASE_SKIP || scan_phase == PHASE_SIGN) begin
            // A leading zero is a digit and may pick the radix.
            if (c == CH_ZERO && (radix_mode == MODE_AUTO || radix_mode == MODE_HEX)) begin
               field_radix = (radix_mode == MODE_AUTO) ? 8 : 16;
               digit_seen = 1;
               scan_phase = PHASE_ZERO;
               count_char();
               return;
            end
            scan_phase = PHASE_DIGITS;
         end else if (scan_phase == PHASE_ZERO) begin
            if (c == CH_X_LOWER || c == CH_X_UPPER) begin
               field_radix = 16;
               scan_phase = PHASE_DIGITS;
               count_char();
               return;
            end
            scan_phase = PHASE_DIGITS;
         end
         if (c >= CH_ZERO && c <= CH_NINE) d = c - CH_ZERO;
         else if (c >= CH_A_LOWER && c <= CH_F_LOWER) d = c - CH_A_LOWER + 10;
         else if (c >= CH_A_UPPER && c <= CH_F_UPPER) d = c - CH_A_UPPER + 10;
         else d = 99;
         if (d >= field_radix) begin
            close_field(1);
            return;
         end
         digit_seen = 1;
         if (!saturated) begin
            if (accumulator > (VALUE_MASK - 64'(d)) / 64'(field_radix)) saturated = 1;
            else accumulator = accumulator * 64'(field_radix) + 64'(d);
         end
         count_char();
      endfunction

      // Compare a response with the oldest prediction.
      function void check_field(logic [63:0] value, logic no_digits, logic char_returned);
         field_result_type exp;
         if (expected_fields.size() == 0) begin
            $error("unexpected response: value %h no_digits %b char_returned %b",
                   value, no_digits, char_returned);
            errors++;
            return;
         end
         exp = expected_fields.pop_front();
         if (value !== exp.value) begin
            $error("value: expected %h, got %h", exp.value, value);
            errors++;
         end
         if (no_digits !== exp.no_digits) begin
            $error("no_digits: expected %b, got %b", exp.no_digits, no_digits);
            errors++;
         end
         if (char_returned !== exp.char_returned) begin
            $error("char_returned: expected %b, got %b", exp.char_returned, char_returned);
            errors++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   aifs_req_if req ();
   aifs_rsp_if rsp ();

   field_value_tracker tracker;
   int  src_idle_pct;
   int  snk_idle_pct;
   int  requests_sent;
   bit  pressure_armed;
   bit  pressure_done;

   ascii_integer_field_scanner_unit #(.VALUE_BITS(VALUE_BITS)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req),
      .rsp_if           (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Response side: random stalls, plus one long hold-off when armed.
   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (pressure_armed && !pressure_done) begin
            rsp.ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_done = 1;
         end else begin
            rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
         end
      end
   end

   // Response checking.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         tracker.check_field(rsp.value, rsp.no_digits, rsp.char_returned);
      end
   end

   // Offer one request and wait for it to be taken.
   task automatic push_request(input logic [7:0] c, input logic at_end);
      while ($urandom_range(99) < src_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.ch <= c;
      req.at_end <= at_end;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      tracker.take_char(c, at_end);
      requests_sent++;
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      tracker.set_register(idx, data);
   endtask

   // Write all four registers; unused upper data bits carry random values.
   task automatic apply_settings(input logic [1:0] mode, input logic [7:0] width,
                                 input logic sgn, input logic [1:0] size);
      write_register(CSR_RADIX_MODE, {6'($urandom), mode});
      write_register(CSR_WIDTH_LIMIT, width);
      write_register(CSR_IS_SIGNED, {7'($urandom), sgn});
      write_register(CSR_RESULT_SIZE, {6'($urandom), size});
      csr_write_enable <= 1'b0;
   endtask

   // Close any open field and let the block drain before reconfiguring.
   task automatic settle_block();
      push_request(8'($urandom), 1'b1);
      req.valid <= 1'b0;
      while (tracker.expected_fields.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Mostly well-formed fields with random content, some noise.
   task automatic send_random_field(input logic [1:0] mode);
      int          pick;
      int          d;
      int          digit_radix;
      logic [7:0]  c;
      if ($urandom_range(99) < 15) begin
         repeat ($urandom_range(1, 4)) push_request(8'($urandom), $urandom_range(9) == 0);
         return;
      end
      // Leading white space.
      repeat ($urandom_range(0, 2)) begin
         pick = $urandom_range(0, 5);
         c = (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
         push_request(c, 1'b0);
      end
      pick = $urandom_range(0, 2);
      if (pick == 1) push_request(CH_PLUS, 1'b0);
      else if (pick == 2) push_request(CH_MINUS, 1'b0);
      digit_radix = (mode == MODE_OCT) ? 8 : (mode == MODE_HEX) ? 16 : 10;
      // Optional 0 or 0x prefix.
      pick = $urandom_range(0, 3);
      if (pick >= 2) begin
         push_request(CH_ZERO, 1'b0);
         if (mode == MODE_AUTO) digit_radix = 8;
         if (pick == 3) begin
            push_request($urandom_range(1) ? CH_X_LOWER : CH_X_UPPER, 1'b0);
            if (mode == MODE_AUTO || mode == MODE_HEX) digit_radix = 16;
         end
      end
      // Digits; long runs drive the accumulator into saturation.
      repeat (($urandom_range(9) == 0) ? $urandom_range(15, 25) : $urandom_range(0, 8)) begin
         d = ($urandom_range(9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, digit_radix - 1);
         if (d < 10) c = CH_ZERO + 8'(d);
         else c = ($urandom_range(1) ? CH_A_LOWER : CH_A_UPPER) + 8'(d - 10);
         push_request(c, 1'b0);
      end
      case ($urandom_range(0, 3))
         0:       push_request(8'($urandom), 1'b1);
         1:       push_request(CH_NUL, 1'b0);
         2:       push_request(8'($urandom), 1'b0);
         default: push_request(CH_SPACE, 1'b0);
      endcase
   endtask

   // Main sequence.
   initial begin
      int start_count;
      tracker = new();
      reset = 1'b1;
      req.valid = 1'b0;
      req.ch = '0;
      req.at_end = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      src_idle_pct = 13;
      snk_idle_pct = 51;
      requests_sent = 0;
      pressure_armed = 0;
      pressure_done = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: white space, negative decimal, a returned terminator.
      push_request(CH_SPACE, 1'b0);
      push_request(CH_TAB, 1'b0);
      push_request(CH_CR, 1'b0);
      push_request(CH_MINUS, 1'b0);
      push_request(CH_ZERO + 8'd1, 1'b0);
      push_request(CH_ZERO + 8'd2, 1'b0);
      push_request(8'hFF, 1'b0);
      // A sign with no digits, then end of input while skipping.
      push_request(CH_PLUS, 1'b0);
      push_request(8'hFF, 1'b1);
      push_request(8'h00, 1'b1);
      // A zero byte ends the field.
      push_request(CH_ZERO + 8'd7, 1'b0);
      push_request(CH_NUL, 1'b0);
      settle_block();

      // Automatic radix, unsigned 64 bits: bare 0x prefix, negated octal.
      apply_settings(MODE_AUTO, 8'd0, 1'b0, SIZE_64);
      push_request(CH_ZERO, 1'b0);
      push_request(CH_X_LOWER, 1'b0);
      push_request(CH_X_LOWER - 8'd17, 1'b0);
      push_request(CH_MINUS, 1'b0);
      push_request(CH_ZERO, 1'b0);
      push_request(CH_ZERO + 8'd1, 1'b0);
      push_request(CH_ZERO + 8'd7, 1'b0);
      push_request(8'h00, 1'b1);
      settle_block();

      // Hexadecimal with a field width of three, cut to 8 bits.
      apply_settings(MODE_HEX, 8'd3, 1'b1, SIZE_8);
      repeat (4) push_request(CH_F_UPPER, 1'b0);
      push_request(8'h00, 1'b1);
      settle_block();

      // Random phases over a spread of settings and idle patterns.
      for (int k = 0; k < PHASE_COUNT; k++) begin
         logic [7:0] width;
         case (k % 5)
            1:       width = 8'd255;
            2:       width = 8'd1;
            3:       width = 8'($urandom_range(2, 24));
            default: width = 8'd0;
         endcase
         apply_settings(2'(k % 4), width, 1'((k / 2) % 2), 2'((k + k / 4) % 4));
         if (k < 4) begin
            src_idle_pct = 13;
            snk_idle_pct = 51;
         end else if (k < 8) begin
            src_idle_pct = 51;
            snk_idle_pct = 13;
         end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end
         if (k == 9) pressure_armed = 1;
         start_count = requests_sent;
         while (requests_sent - start_count < REQUESTS_PER_PHASE) send_random_field(2'(k % 4));
         settle_block();
      end

      repeat (10) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("ascii_integer_field_scanner_unit_tb: clean");
      end else begin
         $display("ascii_integer_field_scanner_unit_tb: errors");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #3200000;
      $display("ascii_integer_field_scanner_unit_tb: errors");
      $finish;
   end

endmodule
